>>> rtl/mcs_pkg.sv
`default_nettype none
package mcs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int SIG_W    = 33;
    localparam int MUL_B_W  = 17;
    localparam int ACC_W    = SIG_W + MUL_B_W;
    localparam int HOLD_W   = 15;

    localparam int SHIFT_NARROW = 14;
    localparam int SHIFT_WIDE   = 28;

    localparam logic signed [MUL_B_W-1:0] Q14_ONE = MUL_B_W'(16384);
    localparam logic signed [MUL_B_W-1:0] PAN_MAX = MUL_B_W'(16384);
    localparam logic signed [MUL_B_W-1:0] PAN_MIN = MUL_B_W'(-16384);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    localparam logic [COEF_W-1:0] GAIN_RESET = COEF_W'(16384);

    typedef enum logic [1:0] {
        CFG_GAIN,
        CFG_PAN,
        CFG_SEND_ONE,
        CFG_SEND_TWO
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND1,
        ST_SEND2,
        ST_GAIN,
        ST_METER,
        ST_LEFT,
        ST_RIGHT,
        ST_DONE
    } t_state;

    typedef enum logic {
        MA_SAMPLE,
        MA_SIG
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_SEND1,
        MB_SEND2,
        MB_GAIN,
        MB_LEFT,
        MB_RIGHT
    } t_mul_b;

    typedef enum logic [1:0] {
        RN_SEND1,
        RN_SEND2,
        RN_LEFT,
        RN_RIGHT
    } t_rnd;

endpackage
`default_nettype wire

>>> rtl/mcs_in_if.sv
`default_nettype none
interface mcs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;
    logic               button;
    logic               chain_valid;
    logic signed [15:0] chain_left;
    logic signed [15:0] chain_right;
    logic signed [15:0] chain_send_one;
    logic signed [15:0] chain_send_two;

    modport source (
        output valid, sample_in, button, chain_valid,
               chain_left, chain_right, chain_send_one, chain_send_two,
        input  ready
    );
    modport sink (
        input  valid, sample_in, button, chain_valid,
               chain_left, chain_right, chain_send_one, chain_send_two,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/mcs_out_if.sv
`default_nettype none
interface mcs_out_if #(
    parameter int SEGMENTS = 11
);
    logic                valid;
    logic                ready;
    logic signed [15:0]  left_out;
    logic signed [15:0]  right_out;
    logic signed [15:0]  send_one_out;
    logic signed [15:0]  send_two_out;
    logic [SEGMENTS-1:0] meter_lights;
    logic                run_lamp;

    modport source (
        output valid, left_out, right_out, send_one_out, send_two_out,
               meter_lights, run_lamp,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out, send_one_out, send_two_out,
               meter_lights, run_lamp,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/mcs_meter.sv
`default_nettype none
module mcs_meter #(
    parameter int SEGMENTS    = 11,
    parameter int HOLD_NORMAL = 5000,
    parameter int HOLD_CLIP   = 20000,
    parameter int VOLT_STEP   = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_update,
    input  logic signed [mcs_pkg::SIG_W-1:0]  i_sig,
    output logic [SEGMENTS-1:0]               o_lights
);
    import mcs_pkg::*;

    logic [HOLD_W-1:0]  r_hold [SEGMENTS];
    logic [HOLD_W-1:0]  n_hold [SEGMENTS];
    logic [HOLD_W-1:0]  hold_len [SEGMENTS];
    logic [HOLD_W-1:0]  loaded [SEGMENTS];
    logic [SEGMENTS-1:0] hit;
    logic [SEGMENTS-1:0] lit;
    logic [SEGMENTS-1:0] r_lights;

    // segment g lights while the signal exceeds g volts at Q.14 scale
    for (genvar g = 0; g < SEGMENTS; g++) begin : g_seg
        localparam logic signed [SIG_W-1:0] THR =
            SIG_W'(longint'(g) * longint'(VOLT_STEP) * 64'sd16384);
        assign hit[g]      = (i_sig > THR);
        assign hold_len[g] = (g + 1 < SEGMENTS) ? HOLD_W'(HOLD_NORMAL) : HOLD_W'(HOLD_CLIP);
    end

    // reload on a hit, then count down every live counter
    always_comb begin
        for (int k = 0; k < SEGMENTS; k++) begin
            loaded[k] = hit[k] ? hold_len[k] : r_hold[k];
            lit[k]    = (loaded[k] != '0);
            n_hold[k] = lit[k] ? (loaded[k] - HOLD_W'(1)) : loaded[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SEGMENTS; k++) begin
                r_hold[k] <= '0;
            end
            r_lights <= '0;
        end else if (i_update) begin
            for (int k = 0; k < SEGMENTS; k++) begin
                r_hold[k] <= n_hold[k];
            end
            r_lights <= lit;
        end
    end

    assign o_lights = r_lights;

endmodule
`default_nettype wire

>>> rtl/mixer_channel_strip_with_meter.sv
`default_nettype none
// Mono-to-stereo mixer channel strip with two sends and a peak-hold meter.
// Input channel i_in carries one mono sample, the mute button level and
// optional chain values from an upstream strip; output channel o_out carries
// left, right, both sends, the meter lights and the run lamp for that sample.
// Both channels transfer on a rising edge with valid and ready high.
// Gain, pan and the two send levels are written through i_cfg_we, i_cfg_idx
// and i_cfg_data; the user must write them only while no sample is in
// flight, as the block itself does not enforce this.
// A sample runs through the steps send one, send two, gain, meter, left,
// right and done: a single 33x17 multiplier forms the five products in turn,
// a meter step sits between the gain and the pan products, and one
// rounding/saturation adder finishes each. The sequencer is idle again as the
// result loads into the output register; only then is the next sample taken.
// The output register holds one result; while the receiver stalls a finished
// sample waits in the last sequencer step and no new input is taken.
// Reset restores gain to unity, pan centred, sends off, the channel on and
// all meter hold counters cleared.
module mixer_channel_strip_with_meter #(
    parameter int SEGMENTS    = 11,
    parameter int HOLD_NORMAL = 5000,
    parameter int HOLD_CLIP   = 20000,
    parameter int VOLT_STEP   = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  mcs_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    mcs_in_if.sink                i_in,
    mcs_out_if.source             o_out
);
    import mcs_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [COEF_W-1:0]        r_gain;
    logic signed [COEF_W-1:0] r_pan;
    logic [COEF_W-1:0]        r_send1_lvl;
    logic [COEF_W-1:0]        r_send2_lvl;

    logic r_on;
    logic r_btn_was;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_cl;
    logic signed [SAMPLE_W-1:0] r_cr;
    logic signed [SAMPLE_W-1:0] r_c1;
    logic signed [SAMPLE_W-1:0] r_c2;

    logic signed [ACC_W-1:0]    r_prod;
    logic signed [SIG_W-1:0]    r_sig;
    logic signed [SAMPLE_W-1:0] r_send1;
    logic signed [SAMPLE_W-1:0] r_send2;
    logic signed [SAMPLE_W-1:0] r_left;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_o_left;
    logic signed [SAMPLE_W-1:0] r_o_right;
    logic signed [SAMPLE_W-1:0] r_o_send1;
    logic signed [SAMPLE_W-1:0] r_o_send2;
    logic [SEGMENTS-1:0]        r_o_lights;
    logic                       r_o_on;

    // sequencer controls
    logic   in_take;
    logic   mul_en;
    t_mul_a mul_a_sel;
    t_mul_b mul_b_sel;
    t_rnd   rnd_sel;
    logic   meter_upd;
    logic   out_free;
    logic   out_load;

    logic signed [SIG_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_B_W-1:0] pan_w;
    logic signed [MUL_B_W-1:0] pan_c;
    logic signed [MUL_B_W-1:0] gain_l;
    logic signed [MUL_B_W-1:0] gain_r;
    logic signed [SIG_W-1:0]   sig_now;
    logic [SEGMENTS-1:0]       lights;

    logic                       rnd_wide;
    logic signed [SAMPLE_W-1:0] rnd_chain;
    logic signed [ACC_W-1:0]    rnd_ext;
    logic signed [ACC_W-1:0]    rnd_add;
    logic signed [ACC_W-1:0]    rnd_half;
    logic signed [ACC_W-1:0]    rnd_sum;
    logic signed [ACC_W-1:0]    rnd_shift;
    logic signed [SAMPLE_W-1:0] rnd_out;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RESET;
            r_pan       <= '0;
            r_send1_lvl <= '0;
            r_send2_lvl <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN:     r_gain      <= i_cfg_data;
                CFG_PAN:      r_pan       <= i_cfg_data;
                CFG_SEND_ONE: r_send1_lvl <= i_cfg_data;
                CFG_SEND_TWO: r_send2_lvl <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // balance law: clamp pan, attenuate the opposite side
    always_comb begin
        pan_w = {r_pan[COEF_W-1], r_pan};
        if (pan_w > PAN_MAX) begin
            pan_c = PAN_MAX;
        end else if (pan_w < PAN_MIN) begin
            pan_c = PAN_MIN;
        end else begin
            pan_c = pan_w;
        end
        if (pan_c >= 0) begin
            gain_l = Q14_ONE - pan_c;
            gain_r = Q14_ONE;
        end else begin
            gain_l = Q14_ONE;
            gain_r = Q14_ONE + pan_c;
        end
    end

    // ---------------- sequencer ----------------
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in.valid) n_state = ST_SEND1;
            ST_SEND1: n_state = ST_SEND2;
            ST_SEND2: n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_METER;
            ST_METER: n_state = ST_LEFT;
            ST_LEFT:  n_state = ST_RIGHT;
            ST_RIGHT: n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_take   = 1'b0;
        mul_en    = 1'b0;
        mul_a_sel = MA_SAMPLE;
        mul_b_sel = MB_SEND1;
        rnd_sel   = RN_SEND1;
        meter_upd = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE:  in_take = 1'b1;
            ST_SEND1: begin
                mul_en    = 1'b1;
                mul_b_sel = MB_SEND1;
            end
            ST_SEND2: begin
                mul_en    = 1'b1;
                mul_b_sel = MB_SEND2;
                rnd_sel   = RN_SEND1;
            end
            ST_GAIN: begin
                mul_en    = 1'b1;
                mul_b_sel = MB_GAIN;
                rnd_sel   = RN_SEND2;
            end
            ST_METER: meter_upd = 1'b1;
            ST_LEFT: begin
                mul_en    = 1'b1;
                mul_a_sel = MA_SIG;
                mul_b_sel = MB_LEFT;
            end
            ST_RIGHT: begin
                mul_en    = 1'b1;
                mul_a_sel = MA_SIG;
                mul_b_sel = MB_RIGHT;
                rnd_sel   = RN_LEFT;
            end
            ST_DONE: begin
                rnd_sel  = RN_RIGHT;
                out_load = out_free;
            end
            default: ;
        endcase
    end

    assign i_in.ready = in_take;

    // ---------------- input capture ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on      <= 1'b1;
            r_btn_was <= 1'b0;
        end else if (i_in.valid && in_take) begin
            if (i_in.button && !r_btn_was) begin
                r_on <= !r_on;
            end
            r_btn_was <= i_in.button;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_take) begin
            r_sample <= i_in.sample_in;
            // drop the chain values when upstream supplies none
            r_cl <= i_in.chain_valid ? i_in.chain_left     : '0;
            r_cr <= i_in.chain_valid ? i_in.chain_right    : '0;
            r_c1 <= i_in.chain_valid ? i_in.chain_send_one : '0;
            r_c2 <= i_in.chain_valid ? i_in.chain_send_two : '0;
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        case (mul_a_sel)
            MA_SAMPLE: mul_a = {{(SIG_W-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
            MA_SIG:    mul_a = r_sig;
            default:   mul_a = r_sig;
        endcase
        case (mul_b_sel)
            MB_SEND1: mul_b = {1'b0, r_send1_lvl};
            MB_SEND2: mul_b = {1'b0, r_send2_lvl};
            MB_GAIN:  mul_b = {1'b0, r_gain};
            MB_LEFT:  mul_b = gain_l;
            MB_RIGHT: mul_b = gain_r;
            default:  mul_b = gain_r;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // muted channel feeds zero to meter and pan stage
    assign sig_now = r_on ? r_prod[SIG_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (meter_upd) begin
            r_sig <= sig_now;
        end
    end

    mcs_meter #(
        .SEGMENTS    (SEGMENTS),
        .HOLD_NORMAL (HOLD_NORMAL),
        .HOLD_CLIP   (HOLD_CLIP),
        .VOLT_STEP   (VOLT_STEP)
    ) u_meter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (meter_upd),
        .i_sig    (sig_now),
        .o_lights (lights)
    );

    // ---------------- round and saturate ----------------
    always_comb begin
        case (rnd_sel)
            RN_SEND1: begin rnd_chain = r_c1; rnd_wide = 1'b0; end
            RN_SEND2: begin rnd_chain = r_c2; rnd_wide = 1'b0; end
            RN_LEFT:  begin rnd_chain = r_cl; rnd_wide = 1'b1; end
            RN_RIGHT: begin rnd_chain = r_cr; rnd_wide = 1'b1; end
            default:  begin rnd_chain = r_cr; rnd_wide = 1'b1; end
        endcase
        rnd_ext = {{(ACC_W-SAMPLE_W){rnd_chain[SAMPLE_W-1]}}, rnd_chain};
        if (rnd_wide) begin
            rnd_add  = rnd_ext <<< SHIFT_WIDE;
            rnd_half = ACC_W'(1) <<< (SHIFT_WIDE - 1);
        end else begin
            rnd_add  = rnd_ext <<< SHIFT_NARROW;
            rnd_half = ACC_W'(1) <<< (SHIFT_NARROW - 1);
        end
        rnd_sum   = r_prod + rnd_add + rnd_half;
        rnd_shift = rnd_wide ? (rnd_sum >>> SHIFT_WIDE) : (rnd_sum >>> SHIFT_NARROW);
        if (rnd_shift > SAT_HI) begin
            rnd_out = SAT_HI[SAMPLE_W-1:0];
        end else if (rnd_shift < SAT_LO) begin
            rnd_out = SAT_LO[SAMPLE_W-1:0];
        end else begin
            rnd_out = rnd_shift[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEND2) begin
            r_send1 <= rnd_out;
        end
        if (r_state == ST_GAIN) begin
            r_send2 <= rnd_out;
        end
        if (r_state == ST_RIGHT) begin
            r_left <= rnd_out;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_left   <= r_left;
            r_o_right  <= rnd_out;
            r_o_send1  <= r_send1;
            r_o_send2  <= r_send2;
            r_o_lights <= lights;
            r_o_on     <= r_on;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.left_out     = r_o_left;
    assign o_out.right_out    = r_o_right;
    assign o_out.send_one_out = r_o_send1;
    assign o_out.send_two_out = r_o_send2;
    assign o_out.meter_lights = r_o_lights;
    assign o_out.run_lamp     = r_o_on;

    // ---------------- assertions ----------------
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_SEND1))
        else $error("accepted sample did not start the sequencer");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == ST_DONE))
        else $error("result appeared outside the final step");

    a_button_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.button && !r_btn_was) |=> (r_on != $past(r_on)))
        else $error("button rising edge did not toggle the channel");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_state != ST_IDLE || $past(r_state) != ST_DONE))
        else $error("finished sample left the sequencer while output stalled");

endmodule
`default_nettype wire

>>> tb/sv/mixer_channel_strip_with_meter_tb.sv
`default_nettype none
module mixer_channel_strip_with_meter_tb;
    import mcs_pkg::*;

    localparam int SEGMENTS      = 11;
    localparam int HOLD_NORMAL   = 5000;
    localparam int HOLD_CLIP     = 20000;
    localparam int VOLT_STEP     = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int PRINT_LIMIT   = 40;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int METER_TAIL    = 40;

    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               button;
        logic               chain_valid;
        logic signed [15:0] chain_left;
        logic signed [15:0] chain_right;
        logic signed [15:0] chain_send_one;
        logic signed [15:0] chain_send_two;
    } strip_in_t;

    typedef struct packed {
        logic signed [15:0]  left_out;
        logic signed [15:0]  right_out;
        logic signed [15:0]  send_one_out;
        logic signed [15:0]  send_two_out;
        logic [SEGMENTS-1:0] meter_lights;
        logic                run_lamp;
    } strip_out_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [15:0] i_cfg_data;

    mcs_in_if                          in_ch ();
    mcs_out_if #(.SEGMENTS(SEGMENTS))  out_ch ();

    mixer_channel_strip_with_meter #(
        .SEGMENTS   (SEGMENTS),
        .HOLD_NORMAL(HOLD_NORMAL),
        .HOLD_CLIP  (HOLD_CLIP),
        .VOLT_STEP  (VOLT_STEP)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    // strip state and settings as the predictor sees them
    logic [15:0]        gain_q14;
    logic signed [15:0] pan_q14;
    logic [15:0]        send_one_q14;
    logic [15:0]        send_two_q14;
    logic               chan_on;
    logic               button_prev;
    logic [HOLD_W-1:0]  seg_hold [SEGMENTS];

    strip_out_t expected_mix[$];

    int   errors         = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_off_left  = 0;
    logic button_level   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [15:0] round_to_sample(longint x, int sh);
        longint r;
        r = (x + (longint'(1) <<< (sh - 1))) >>> sh;
        if (r > 32767)
            r = 32767;
        else if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic strip_out_t mix_predict(strip_in_t it);
        strip_out_t res;
        longint s, sig, cl, cr, c1, c2, p, pl, pr;
        s  = longint'($signed(it.sample_in));
        cl = it.chain_valid ? longint'($signed(it.chain_left)) : 0;
        cr = it.chain_valid ? longint'($signed(it.chain_right)) : 0;
        c1 = it.chain_valid ? longint'($signed(it.chain_send_one)) : 0;
        c2 = it.chain_valid ? longint'($signed(it.chain_send_two)) : 0;

        if (it.button && !button_prev)
            chan_on = !chan_on;
        button_prev = it.button;

        res.send_one_out = round_to_sample(s * longint'(send_one_q14) + c1 * 16384, 14);
        res.send_two_out = round_to_sample(s * longint'(send_two_q14) + c2 * 16384, 14);

        sig = chan_on ? s * longint'(gain_q14) : 0;

        // reload on threshold, then light and count down every live segment
        for (int i = 0; i < SEGMENTS; i++) begin
            if (sig > longint'(i) * VOLT_STEP * 16384)
                seg_hold[i] = (i + 1 < SEGMENTS) ? HOLD_W'(HOLD_NORMAL) : HOLD_W'(HOLD_CLIP);
        end
        res.meter_lights = '0;
        for (int i = 0; i < SEGMENTS; i++) begin
            if (seg_hold[i] != 0) begin
                seg_hold[i] = seg_hold[i] - 1'b1;
                res.meter_lights[i] = 1'b1;
            end
        end

        p = longint'($signed(pan_q14));
        if (p > 16384)
            p = 16384;
        if (p < -16384)
            p = -16384;
        pl = (p >= 0) ? 16384 - p : 16384;
        pr = (p >= 0) ? 16384 : 16384 + p;

        res.left_out  = round_to_sample(sig * pl + (cl <<< 28), 28);
        res.right_out = round_to_sample(sig * pr + (cr <<< 28), 28);
        res.run_lamp  = chan_on;
        return res;
    endfunction

    function automatic strip_in_t mk_item(logic signed [15:0] sample, logic button,
                                          logic cv, logic signed [15:0] cl,
                                          logic signed [15:0] cr, logic signed [15:0] c1,
                                          logic signed [15:0] c2);
        strip_in_t it;
        it.sample_in      = sample;
        it.button         = button;
        it.chain_valid    = cv;
        it.chain_left     = cl;
        it.chain_right    = cr;
        it.chain_send_one = c1;
        it.chain_send_two = c2;
        return it;
    endfunction

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return 16'($urandom_range(15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic strip_in_t random_item();
        // hold the button level for a few samples so edges stay sparse
        if ($urandom_range(3) == 0)
            button_level = !button_level;
        return mk_item(random_sample(), button_level, 1'($urandom_range(1)),
                       random_sample(), random_sample(), random_sample(), random_sample());
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'd16384;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_pan();
        case ($urandom_range(6))
            0:       return 16'(-16384);
            1:       return 16'd16384;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'd0;
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN:     gain_q14     = data;
            CFG_PAN:      pan_q14      = data;
            CFG_SEND_ONE: send_one_q14 = data;
            CFG_SEND_TWO: send_two_q14 = data;
        endcase
    endtask

    task automatic set_mix(logic [15:0] gain, logic [15:0] pan,
                           logic [15:0] lvl_one, logic [15:0] lvl_two);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_PAN, pan);
        write_reg(CFG_SEND_ONE, lvl_one);
        write_reg(CFG_SEND_TWO, lvl_two);
    endtask

    // drop valid and hold until every result is back
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_mix.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(strip_in_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid          <= 1'b1;
        in_ch.sample_in      <= it.sample_in;
        in_ch.button         <= it.button;
        in_ch.chain_valid    <= it.chain_valid;
        in_ch.chain_left     <= it.chain_left;
        in_ch.chain_right    <= it.chain_right;
        in_ch.chain_send_one <= it.chain_send_one;
        in_ch.chain_send_two <= it.chain_send_two;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        expected_mix.push_back(mix_predict(it));
    endtask

    task automatic test_signal_extremes();
        send_item(mk_item(16'sd0, 1'b0, 1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_item(mk_item(16'sd1, 1'b0, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        // exactly on a threshold must not light the segment
        send_item(mk_item(16'sd1024, 1'b0, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(16'sd1025, 1'b0, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(16'sd10240, 1'b0, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(16'sd10241, 1'b0, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(16'sh8000, 1'b0, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        send_item(mk_item(16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    endtask

    task automatic test_mute_button();
        send_item(mk_item(16'sh7FFF, 1'b1, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(16'sd500, 1'b1, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(16'sd10241, 1'b0, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(16'sd10241, 1'b1, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(16'sd3000, 1'b0, 1'b1, 16'sd7, -16'sd7, 16'sd1, -16'sd1));
    endtask

    task automatic test_pan_and_levels();
        wait_idle();
        set_mix(16'hFFFF, 16'h8000, 16'd32768, 16'hFFFF);
        send_item(mk_item(16'sh7FFF, 1'b0, 1'b1, -16'sd1, 16'sd2, -16'sd3, 16'sd4));
        send_item(mk_item(16'sh8000, 1'b0, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(-16'sd1, 1'b0, 1'b0, '0, '0, '0, '0));
        wait_idle();
        set_mix(16'd0, 16'h7FFF, 16'd1, 16'd16384);
        send_item(mk_item(16'sh7FFF, 1'b0, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(16'sh8000, 1'b0, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        wait_idle();
        set_mix(16'd16384, 16'd16384, 16'd0, 16'd0);
        send_item(mk_item(16'sd12345, 1'b0, 1'b1, 16'sd100, 16'sd100, 16'sd100, 16'sd100));
        wait_idle();
        write_reg(CFG_PAN, 16'(-16384));
        send_item(mk_item(16'sd12345, 1'b0, 1'b0, '0, '0, '0, '0));
        wait_idle();
        write_reg(CFG_PAN, 16'hFFFF);
        send_item(mk_item(16'sh7FFF, 1'b0, 1'b0, '0, '0, '0, '0));
    endtask

    // halves in every output: ties go towards plus infinity
    task automatic test_rounding();
        wait_idle();
        set_mix(16'd1, 16'd0, 16'd1, 16'd3);
        send_item(mk_item(16'sd8192, 1'b0, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(-16'sd8192, 1'b0, 1'b0, '0, '0, '0, '0));
        send_item(mk_item(16'sd8191, 1'b0, 1'b1, 16'sd1, -16'sd1, 16'sd0, 16'sd0));
        send_item(mk_item(-16'sd8193, 1'b0, 1'b1, -16'sd1, 16'sd1, 16'sd0, 16'sd0));
    endtask

    // light every segment once, then feed only non-positive samples while the holds run
    task automatic test_meter_hold();
        strip_in_t it;
        wait_idle();
        set_mix(16'd16384, 16'd0, 16'd16384, 16'd16384);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        button_level   = 1'b0;
        send_item(mk_item(16'sh7FFF, 1'b0, 1'b0, '0, '0, '0, '0));
        repeat (METER_TAIL) begin
            it = mk_item(16'($urandom), 1'b0, 1'($urandom_range(1)),
                         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            if (it.sample_in > 0)
                it.sample_in = -it.sample_in;
            send_item(it);
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 300;
        repeat (48) send_item(random_item());
        wait_idle();
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            case (phase)
                0:       set_mix(16'd32768, 16'(-16384), 16'd32768, 16'd32768);
                5:       set_mix(16'd16384, 16'd0, 16'd16384, 16'd8192);
                default: set_mix(pick_level(), pick_pan(), pick_level(), pick_level());
            endcase
            send_idle_pct  = (phase < 2) ? 28 : (phase < 4) ? 45 : 0;
            recv_stall_pct = (phase < 2) ? 45 : (phase < 4) ? 28 : 0;
            repeat (ITEMS_PER_PHASE) send_item(random_item());
        end
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        strip_out_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_mix.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_mix.pop_front();
                check_field("left_out", out_ch.left_out, $signed(want.left_out));
                check_field("right_out", out_ch.right_out, $signed(want.right_out));
                check_field("send_one_out", out_ch.send_one_out, $signed(want.send_one_out));
                check_field("send_two_out", out_ch.send_two_out, $signed(want.send_two_out));
                check_field("meter_lights", out_ch.meter_lights, want.meter_lights);
                check_field("run_lamp", out_ch.run_lamp, want.run_lamp);
            end
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_GAIN;
        i_cfg_data           = '0;
        in_ch.valid          = 1'b0;
        in_ch.sample_in      = '0;
        in_ch.button         = 1'b0;
        in_ch.chain_valid    = 1'b0;
        in_ch.chain_left     = '0;
        in_ch.chain_right    = '0;
        in_ch.chain_send_one = '0;
        in_ch.chain_send_two = '0;

        gain_q14     = 16'd16384;
        pan_q14      = '0;
        send_one_q14 = '0;
        send_two_q14 = '0;
        chan_on      = 1'b1;
        button_prev  = 1'b0;
        for (int i = 0; i < SEGMENTS; i++)
            seg_hold[i] = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_signal_extremes();
        test_mute_button();
        test_pan_and_levels();
        test_rounding();
        test_meter_hold();
        test_backpressure();
        test_random_mix();
        wait_idle();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
